// ----- hdl/agpw_pkg.sv -----
// Shared types and codes for the adaptive gray pixel whitener.
`default_nettype none
package agpw_pkg;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_NQ_INIT,
    OP_MUL,
    OP_SS_INIT,
    OP_NN_INIT,
    OP_DIV_INIT,
    OP_DIV,
    OP_SQRT_INIT,
    OP_SQRT,
    OP_MEAN_INIT,
    OP_MEAN_SAVE,
    OP_FINAL
  } op_t;

  typedef struct packed {
    op_t  op;
    logic sel;
    logic stat_acc;
    logic app_acc;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  localparam logic [7:0] PIX_WHITE = 8'd255;
  localparam logic [9:0] TOL_MAX = 10'd1023;

endpackage
`default_nettype wire

// ----- hdl/agpw_ctrl.sv -----
// Controller: input handshake and end-of-frame sequencing.
`default_nettype none
module agpw_ctrl #(
  parameter int MAX_PIXELS_LOG2 = 24,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_req_type,
  input  wire logic          in_frame_last,
  input  wire agpw_pkg::sts_t sts,
  output logic               in_stall,
  output agpw_pkg::cmd_t     cmd
);

  localparam int WC = MAX_PIXELS_LOG2 + 1;
  localparam int WN = 2 * WC + 20 + 2 * FRACTION_BITS;
  localparam int WMUL = WC + 10;
  localparam int CW = $clog2(WN + 1);

  typedef enum logic [14:0] {
    ST_IDLE      = 15'b000000000000001,
    ST_NQ_INIT   = 15'b000000000000010,
    ST_NQ_MUL    = 15'b000000000000100,
    ST_SS_INIT   = 15'b000000000001000,
    ST_SS_MUL    = 15'b000000000010000,
    ST_NN_INIT   = 15'b000000000100000,
    ST_NN_MUL    = 15'b000000001000000,
    ST_DIV_INIT  = 15'b000000010000000,
    ST_DEV_DIV   = 15'b000000100000000,
    ST_SQRT_INIT = 15'b000001000000000,
    ST_SQRT      = 15'b000010000000000,
    ST_MEAN_INIT = 15'b000100000000000,
    ST_MEAN_DIV  = 15'b001000000000000,
    ST_MEAN_SAVE = 15'b010000000000000,
    ST_FINAL     = 15'b100000000000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          sel_r, sel_nxt;
  logic          acc;

  assign in_stall = (state_r != ST_IDLE) || !sts.out_free;
  assign acc = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    sel_nxt = sel_r;
    cmd.op = agpw_pkg::OP_NONE;
    cmd.sel = sel_r;
    cmd.stat_acc = acc && !in_req_type;
    cmd.app_acc = acc && in_req_type;
    case (state_r)
      ST_IDLE: begin
        if (acc && !in_req_type && in_frame_last) begin
          state_nxt = ST_NQ_INIT;
          sel_nxt = 1'b0;
        end
      end
      ST_NQ_INIT: begin
        cmd.op = agpw_pkg::OP_NQ_INIT;
        cnt_nxt = CW'(WMUL - 1);
        state_nxt = ST_NQ_MUL;
      end
      ST_NQ_MUL: begin
        cmd.op = agpw_pkg::OP_MUL;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = ST_SS_INIT;
      end
      ST_SS_INIT: begin
        cmd.op = agpw_pkg::OP_SS_INIT;
        cnt_nxt = CW'(WMUL - 1);
        state_nxt = ST_SS_MUL;
      end
      ST_SS_MUL: begin
        cmd.op = agpw_pkg::OP_MUL;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = ST_NN_INIT;
      end
      ST_NN_INIT: begin
        cmd.op = agpw_pkg::OP_NN_INIT;
        cnt_nxt = CW'(WMUL - 1);
        state_nxt = ST_NN_MUL;
      end
      ST_NN_MUL: begin
        cmd.op = agpw_pkg::OP_MUL;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.op = agpw_pkg::OP_DIV_INIT;
        cnt_nxt = CW'(WN - 1);
        state_nxt = ST_DEV_DIV;
      end
      ST_DEV_DIV: begin
        cmd.op = agpw_pkg::OP_DIV;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = ST_SQRT_INIT;
      end
      ST_SQRT_INIT: begin
        cmd.op = agpw_pkg::OP_SQRT_INIT;
        cnt_nxt = CW'(WN / 2 - 1);
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.op = agpw_pkg::OP_SQRT;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = ST_MEAN_INIT;
      end
      ST_MEAN_INIT: begin
        cmd.op = agpw_pkg::OP_MEAN_INIT;
        cnt_nxt = CW'(WN - 1);
        state_nxt = ST_MEAN_DIV;
      end
      ST_MEAN_DIV: begin
        cmd.op = agpw_pkg::OP_DIV;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = ST_MEAN_SAVE;
      end
      ST_MEAN_SAVE: begin
        cmd.op = agpw_pkg::OP_MEAN_SAVE;
        if (sel_r) begin
          state_nxt = ST_FINAL;
        end else begin
          sel_nxt = 1'b1;
          state_nxt = ST_NQ_INIT;
        end
      end
      ST_FINAL: begin
        if (sts.out_free) begin
          cmd.op = agpw_pkg::OP_FINAL;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      sel_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      sel_r <= sel_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/agpw_dpath.sv -----
// Datapath: accumulators, shared multiply/divide/root engine, parameters, result register.
`default_nettype none
module agpw_dpath #(
  parameter int MAX_PIXELS_LOG2 = 24,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire agpw_pkg::cmd_t cmd,
  output agpw_pkg::sts_t      sts,
  input  wire logic [7:0]     in_blue_in,
  input  wire logic [7:0]     in_green_in,
  input  wire logic [7:0]     in_red_in,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [7:0]          out_blue_out,
  output logic [7:0]          out_green_out,
  output logic [7:0]          out_red_out,
  output logic                out_whitened,
  output logic                out_params_ready,
  output logic [9:0]          out_tolerance_out,
  output logic signed [8:0]   out_min_intensity_out
);

  localparam int F = FRACTION_BITS;
  localparam int WC = MAX_PIXELS_LOG2 + 1;
  localparam int WIS = WC + 8;
  localparam int WIQ = WC + 16;
  localparam int WDS = WC + 10;
  localparam int WDQ = WC + 18;
  localparam int WN = 2 * WC + 20 + 2 * F;
  localparam int WV = F + 9;

  // pixel terms
  logic [9:0]  sum3;
  logic [19:0] prod3;
  logic [7:0]  inten, drg, drb, dgb;
  logic [15:0] isq;
  logic [9:0]  dsum;
  logic [17:0] dsq;

  assign sum3 = {2'b0, in_blue_in} + {2'b0, in_green_in} + {2'b0, in_red_in};
  assign prod3 = {10'b0, sum3} * 20'd683;
  assign inten = prod3[18:11];
  assign drg = (in_red_in > in_green_in) ? in_red_in - in_green_in : in_green_in - in_red_in;
  assign drb = (in_red_in > in_blue_in) ? in_red_in - in_blue_in : in_blue_in - in_red_in;
  assign dgb = (in_green_in > in_blue_in) ? in_green_in - in_blue_in : in_blue_in - in_green_in;
  assign isq = {8'b0, inten} * {8'b0, inten};
  assign dsum = {2'b0, drg} + {2'b0, drb} + {2'b0, dgb};
  assign dsq = {2'b0, {8'b0, drg} * {8'b0, drg}} + {2'b0, {8'b0, drb} * {8'b0, drb}}
             + {2'b0, {8'b0, dgb} * {8'b0, dgb}};

  // accumulators
  logic [WC-1:0]  cnt_r, cnt_nxt;
  logic [WIS-1:0] is_r, is_nxt;
  logic [WIQ-1:0] iq_r, iq_nxt;
  logic [WDS-1:0] ds_r, ds_nxt;
  logic [WDQ-1:0] dq_r, dq_nxt;
  logic [WC:0]    cnt_add;
  logic [WIS:0]   is_add;
  logic [WIQ:0]   iq_add;
  logic [WDS:0]   ds_add;
  logic [WDQ:0]   dq_add;

  assign cnt_add = {1'b0, cnt_r} + (WC + 1)'(1);
  assign is_add = {1'b0, is_r} + (WIS + 1)'(inten);
  assign iq_add = {1'b0, iq_r} + (WIQ + 1)'(isq);
  assign ds_add = {1'b0, ds_r} + (WDS + 1)'(dsum);
  assign dq_add = {1'b0, dq_r} + (WDQ + 1)'(dsq);

  // parameter registers
  logic [9:0]        tol_r, tol_nxt, tol_new;
  logic signed [8:0] min_r, min_nxt, min_new;

  // engine
  logic [WN:0]   acc_r, acc_nxt;
  logic [WN-1:0] opa_r, opa_nxt, opb_r, opb_nxt, p1_r, p1_nxt;
  logic [WV-1:0] meani_r, meani_nxt, meand_r, meand_nxt;
  logic [WV-1:0] devi_r, devi_nxt, devd_r, devd_nxt;
  logic [WC+1:0] n_sel;
  logic [WN-1:0] q_sel, s_sel, diff;
  logic [WN:0]   rem_sh, sq_sh, sq_trial;

  assign n_sel = cmd.sel ? ({2'b0, cnt_r} + {1'b0, cnt_r, 1'b0}) : {2'b0, cnt_r};
  assign q_sel = cmd.sel ? WN'(dq_r) : WN'(iq_r);
  assign s_sel = cmd.sel ? WN'(ds_r) : WN'(is_r);
  assign diff = (p1_r >= acc_r[WN-1:0]) ? p1_r - acc_r[WN-1:0] : '0;
  assign rem_sh = {acc_r[WN-1:0], opb_r[WN-1]};
  assign sq_sh = {acc_r[WN-2:0], opb_r[WN-1:WN-2]};
  assign sq_trial = {opa_r[WN-2:0], 2'b01};

  // parameter arithmetic
  logic [WV+1:0]      tsum, tshift;
  logic signed [WV:0] mdiff;
  logic [WV:0]        mabs, mmag;

  assign tsum = {2'b0, meand_r} + {2'b0, devd_r} + ((WV + 2)'(6) << F);
  assign tshift = tsum >> (F - 1);
  assign tol_new = (|tshift[WV+1:10]) ? agpw_pkg::TOL_MAX : tshift[9:0];
  assign mdiff = $signed({1'b0, meani_r}) - $signed({1'b0, devi_r});
  assign mabs = mdiff[WV] ? (WV + 1)'(-mdiff) : mdiff;
  assign mmag = mabs >> F;

  always_comb begin
    if (mdiff[WV]) begin
      if (mmag > (WV + 1)'(128)) min_new = -9'sd128;
      else min_new = $signed(9'(9'd0 - mmag[8:0]));
    end else begin
      if (mmag > (WV + 1)'(255)) min_new = 9'sd255;
      else min_new = $signed(mmag[8:0]);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    is_nxt = is_r;
    iq_nxt = iq_r;
    ds_nxt = ds_r;
    dq_nxt = dq_r;
    tol_nxt = tol_r;
    min_nxt = min_r;
    acc_nxt = acc_r;
    opa_nxt = opa_r;
    opb_nxt = opb_r;
    p1_nxt = p1_r;
    meani_nxt = meani_r;
    meand_nxt = meand_r;
    devi_nxt = devi_r;
    devd_nxt = devd_r;
    if (cmd.stat_acc) begin
      cnt_nxt = cnt_add[WC] ? '1 : cnt_add[WC-1:0];
      is_nxt = is_add[WIS] ? '1 : is_add[WIS-1:0];
      iq_nxt = iq_add[WIQ] ? '1 : iq_add[WIQ-1:0];
      ds_nxt = ds_add[WDS] ? '1 : ds_add[WDS-1:0];
      dq_nxt = dq_add[WDQ] ? '1 : dq_add[WDQ-1:0];
    end
    case (cmd.op)
      agpw_pkg::OP_NQ_INIT: begin
        acc_nxt = '0;
        opa_nxt = q_sel;
        opb_nxt = WN'(n_sel);
      end
      agpw_pkg::OP_MUL: begin
        if (opb_r[0]) acc_nxt = acc_r + {1'b0, opa_r};
        opa_nxt = opa_r << 1;
        opb_nxt = opb_r >> 1;
      end
      agpw_pkg::OP_SS_INIT: begin
        p1_nxt = acc_r[WN-1:0];
        acc_nxt = '0;
        opa_nxt = s_sel;
        opb_nxt = s_sel;
      end
      agpw_pkg::OP_NN_INIT: begin
        p1_nxt = diff << (2 * F);
        acc_nxt = '0;
        opa_nxt = WN'(n_sel);
        opb_nxt = WN'(n_sel);
      end
      agpw_pkg::OP_DIV_INIT: begin
        opa_nxt = acc_r[WN-1:0];
        opb_nxt = p1_r;
        acc_nxt = '0;
      end
      agpw_pkg::OP_DIV: begin
        if (rem_sh >= {1'b0, opa_r}) begin
          acc_nxt = rem_sh - {1'b0, opa_r};
          opb_nxt = {opb_r[WN-2:0], 1'b1};
        end else begin
          acc_nxt = rem_sh;
          opb_nxt = {opb_r[WN-2:0], 1'b0};
        end
      end
      agpw_pkg::OP_SQRT_INIT: begin
        acc_nxt = '0;
        opa_nxt = '0;
      end
      agpw_pkg::OP_SQRT: begin
        opb_nxt = opb_r << 2;
        if (sq_sh >= sq_trial) begin
          acc_nxt = sq_sh - sq_trial;
          opa_nxt = {opa_r[WN-2:0], 1'b1};
        end else begin
          acc_nxt = sq_sh;
          opa_nxt = {opa_r[WN-2:0], 1'b0};
        end
      end
      agpw_pkg::OP_MEAN_INIT: begin
        if (cmd.sel) devd_nxt = opa_r[WV-1:0];
        else devi_nxt = opa_r[WV-1:0];
        opa_nxt = WN'(n_sel);
        opb_nxt = s_sel << F;
        acc_nxt = '0;
      end
      agpw_pkg::OP_MEAN_SAVE: begin
        if (cmd.sel) meand_nxt = opb_r[WV-1:0];
        else meani_nxt = opb_r[WV-1:0];
      end
      agpw_pkg::OP_FINAL: begin
        tol_nxt = tol_new;
        min_nxt = min_new;
        cnt_nxt = '0;
        is_nxt = '0;
        iq_nxt = '0;
        ds_nxt = '0;
        dq_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // result register
  logic       oval_r, oval_nxt;
  logic [7:0] ob_r, ob_nxt, og_r, og_nxt, or_r, or_nxt;
  logic       ow_r, ow_nxt, op_r, op_nxt;
  logic [9:0] ot_r, ot_nxt;
  logic signed [8:0] om_r, om_nxt;
  logic       white;

  assign sts.out_free = !oval_r || !out_stall;
  assign white = (drg < tol_r[7:0] || |tol_r[9:8]) && (drb < tol_r[7:0] || |tol_r[9:8])
               && (dgb < tol_r[7:0] || |tol_r[9:8])
               && ($signed({2'b0, inten}) > 10'(min_r));

  always_comb begin
    oval_nxt = oval_r && out_stall;
    ob_nxt = ob_r;
    og_nxt = og_r;
    or_nxt = or_r;
    ow_nxt = ow_r;
    op_nxt = op_r;
    ot_nxt = ot_r;
    om_nxt = om_r;
    if (cmd.app_acc) begin
      oval_nxt = 1'b1;
      ob_nxt = white ? agpw_pkg::PIX_WHITE : in_blue_in;
      og_nxt = white ? agpw_pkg::PIX_WHITE : in_green_in;
      or_nxt = white ? agpw_pkg::PIX_WHITE : in_red_in;
      ow_nxt = white;
      op_nxt = 1'b0;
      ot_nxt = '0;
      om_nxt = '0;
    end else if (cmd.op == agpw_pkg::OP_FINAL) begin
      oval_nxt = 1'b1;
      ob_nxt = '0;
      og_nxt = '0;
      or_nxt = '0;
      ow_nxt = 1'b0;
      op_nxt = 1'b1;
      ot_nxt = tol_new;
      om_nxt = min_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      is_r <= '0;
      iq_r <= '0;
      ds_r <= '0;
      dq_r <= '0;
      tol_r <= '0;
      min_r <= 9'sd255;
      oval_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      is_r <= is_nxt;
      iq_r <= iq_nxt;
      ds_r <= ds_nxt;
      dq_r <= dq_nxt;
      tol_r <= tol_nxt;
      min_r <= min_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    opa_r <= opa_nxt;
    opb_r <= opb_nxt;
    p1_r <= p1_nxt;
    meani_r <= meani_nxt;
    meand_r <= meand_nxt;
    devi_r <= devi_nxt;
    devd_r <= devd_nxt;
    ob_r <= ob_nxt;
    og_r <= og_nxt;
    or_r <= or_nxt;
    ow_r <= ow_nxt;
    op_r <= op_nxt;
    ot_r <= ot_nxt;
    om_r <= om_nxt;
  end

  assign out_valid = oval_r;
  assign out_blue_out = ob_r;
  assign out_green_out = og_r;
  assign out_red_out = or_r;
  assign out_whitened = ow_r;
  assign out_params_ready = op_r;
  assign out_tolerance_out = ot_r;
  assign out_min_intensity_out = om_r;

endmodule
`default_nettype wire

// ----- hdl/adaptive_gray_pixel_whitener.sv -----
// Top level: two-pass gray pixel whitener, controller plus datapath.
// Apply pixel: result the cycle after transfer; one per cycle while idle and out_stall low.
// Statistics pixel: one per cycle while not stalled, no result, except on frame_last.
// Frame end: per statistic set the bit-serial engine runs three multiplies, a divide,
//   a square root and a mean divide; two sets (intensity, channel differences), then the result.
// Reset (synchronous, rst_n low): sums zero, tolerance 0, minimum intensity 255.
`default_nettype none
module adaptive_gray_pixel_whitener #(
  parameter int MAX_PIXELS_LOG2 = 24,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic [7:0]  in_blue_in,
  input  wire logic [7:0]  in_green_in,
  input  wire logic [7:0]  in_red_in,
  input  wire logic        in_frame_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_blue_out,
  output logic [7:0]       out_green_out,
  output logic [7:0]       out_red_out,
  output logic             out_whitened,
  output logic             out_params_ready,
  output logic [9:0]       out_tolerance_out,
  output logic signed [8:0] out_min_intensity_out
);

  agpw_pkg::cmd_t cmd;
  agpw_pkg::sts_t sts;

  agpw_ctrl #(
    .MAX_PIXELS_LOG2(MAX_PIXELS_LOG2),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_req_type(in_req_type),
    .in_frame_last(in_frame_last),
    .sts(sts),
    .in_stall(in_stall),
    .cmd(cmd)
  );

  agpw_dpath #(
    .MAX_PIXELS_LOG2(MAX_PIXELS_LOG2),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dpath (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .sts(sts),
    .in_blue_in(in_blue_in),
    .in_green_in(in_green_in),
    .in_red_in(in_red_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_blue_out(out_blue_out),
    .out_green_out(out_green_out),
    .out_red_out(out_red_out),
    .out_whitened(out_whitened),
    .out_params_ready(out_params_ready),
    .out_tolerance_out(out_tolerance_out),
    .out_min_intensity_out(out_min_intensity_out)
  );

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_req_type && in_frame_last |=> in_stall)
    else $error("no stall after frame end transfer");

  a_params_not_white: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_params_ready |-> !out_whitened && out_red_out == 8'd0)
    else $error("parameter result carries pixel data");

  a_white_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_whitened |-> out_red_out == 8'd255 && out_green_out == 8'd255
      && out_blue_out == 8'd255)
    else $error("whitened pixel not white");

endmodule
`default_nettype wire

// ----- test/adaptive_gray_pixel_whitener_test.sv -----
// Self-checking bench for the adaptive gray pixel whitener: random two-pass frames, scoreboard.
`default_nettype none
module adaptive_gray_pixel_whitener_test;

  localparam int CNT_W = 25;
  localparam int FRAC = 8;
  localparam int FRAME_LAT = 2 * (3 * (CNT_W + 10) + 2 * (2 * CNT_W + 20 + 2 * FRAC)
                             + (2 * CNT_W + 20 + 2 * FRAC) / 2 + 7) + 1;
  localparam int DOG_LIMIT = 20 * FRAME_LAT + 20000;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    logic whitened;
    logic params_ready;
    logic [9:0] tol;
    logic signed [8:0] min_int;
  } pix_res_t;

  class whitener_scoreboard;
    logic [CNT_W-1:0] n_pix;
    logic [CNT_W+7:0] s_int;
    logic [CNT_W+15:0] q_int;
    logic [CNT_W+9:0] s_dif;
    logic [CNT_W+17:0] q_dif;
    logic [9:0] tol;
    logic signed [8:0] min_int;
    pix_res_t pending[$];
    int errors;

    function new();
      clear_sums();
      tol = 0;
      min_int = 9'sd255;
      errors = 0;
    endfunction

    function void clear_sums();
      n_pix = 0; s_int = 0; q_int = 0; s_dif = 0; q_dif = 0;
    endfunction

    function logic [127:0] sat(logic [127:0] acc, logic [127:0] v, int w);
      logic [127:0] mx, s;
      mx = (128'd1 << w) - 1;
      s = acc + v;
      return (s > mx) ? mx : s;
    endfunction

    function void mean_dev(logic [127:0] n, logic [127:0] s, logic [127:0] q,
                           output logic [63:0] mean, output logic [63:0] dev);
      logic [255:0] num, quo;
      logic [63:0] v, res, bt;
      mean = 64'((s << FRAC) / n);
      num = (n * q >= s * s) ? (n * q - s * s) : 0;
      num = num << (2 * FRAC);
      quo = num / (n * n);
      v = (quo[255:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : quo[63:0];
      res = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt = bt >> 2;
      while (bt != 0) begin
        if (v >= res + bt) begin
          v = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
      dev = res;
    endfunction

    function void note_pixel(logic req, logic [7:0] b, logic [7:0] g, logic [7:0] r,
                             logic last);
      pix_res_t e;
      int it, drg, drb, dgb;
      logic [63:0] mi, si, md, sd, t;
      longint m;
      bit wh;
      it = (int'(r) + int'(g) + int'(b)) / 3;
      drg = (r > g) ? r - g : g - r;
      drb = (r > b) ? r - b : b - r;
      dgb = (g > b) ? g - b : b - g;
      e = '0;
      if (req) begin
        wh = drg < tol && drb < tol && dgb < tol && it > int'(min_int);
        e.b = wh ? agpw_pkg::PIX_WHITE : b;
        e.g = wh ? agpw_pkg::PIX_WHITE : g;
        e.r = wh ? agpw_pkg::PIX_WHITE : r;
        e.whitened = wh;
        pending.insert(pending.size(), e);
        return;
      end
      n_pix = CNT_W'(sat(n_pix, 1, CNT_W));
      s_int = (CNT_W + 8)'(sat(s_int, it, CNT_W + 8));
      q_int = (CNT_W + 16)'(sat(q_int, it * it, CNT_W + 16));
      s_dif = (CNT_W + 10)'(sat(s_dif, drg + drb + dgb, CNT_W + 10));
      q_dif = (CNT_W + 18)'(sat(q_dif, drg * drg + drb * drb + dgb * dgb, CNT_W + 18));
      if (!last) return;
      mean_dev(n_pix, s_int, q_int, mi, si);
      mean_dev(n_pix * 3, s_dif, q_dif, md, sd);
      t = ((md + sd + (64'd6 << FRAC)) * 2) >> FRAC;
      tol = (t > agpw_pkg::TOL_MAX) ? agpw_pkg::TOL_MAX : t[9:0];
      m = longint'(mi) - longint'(si);
      m = (m >= 0) ? (m >>> FRAC) : -((-m) >>> FRAC);
      if (m < -128) m = -128;
      if (m > 255) m = 255;
      min_int = m[8:0];
      clear_sums();
      e.params_ready = 1;
      e.tol = tol;
      e.min_int = min_int;
      pending.insert(pending.size(), e);
    endfunction

    task check_result(pix_res_t got);
      pix_res_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected", got, got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) report_mismatch("field mismatch", got, e);
    endtask

    task report_mismatch(string what, pix_res_t got, pix_res_t want);
      errors++;
      $display("MISMATCH %s: got %h want %h", what, got, want);
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_req_type = 0, in_frame_last = 0;
  logic [7:0] in_blue_in = 0, in_green_in = 0, in_red_in = 0;
  logic out_stall = 0;
  wire in_stall, out_valid, out_whitened, out_params_ready;
  wire [7:0] out_blue_out, out_green_out, out_red_out;
  wire [9:0] out_tolerance_out;
  wire signed [8:0] out_min_intensity_out;

  whitener_scoreboard sb;
  int send_idle = 0, recv_stall = 0, hold_off = 0, dog = 0;

  always #4 clk = ~clk;

  adaptive_gray_pixel_whitener dut (.*);

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_pixel(in_req_type, in_blue_in, in_green_in, in_red_in, in_frame_last);
      if (out_valid && !out_stall)
        sb.check_result({out_blue_out, out_green_out, out_red_out, out_whitened,
                         out_params_ready, out_tolerance_out, out_min_intensity_out});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) dog = 0;
      else dog++;
      if (dog >= DOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off--;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  task automatic send_pixel(logic req, logic [7:0] b, logic [7:0] g, logic [7:0] r,
                            logic last);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_req_type <= req;
    in_blue_in <= b;
    in_green_in <= g;
    in_red_in <= r;
    in_frame_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (FRAME_LAT + 10) @(negedge clk);
  endtask

  task automatic random_pixel(int mode, output logic [7:0] b, output logic [7:0] g,
                              output logic [7:0] r);
    logic [7:0] base;
    base = 8'($urandom);
    if (mode == 0) begin
      b = 8'($urandom); g = 8'($urandom); r = 8'($urandom);
    end else begin
      b = 8'(base + $urandom_range(8) - 4);
      g = 8'(base + $urandom_range(8) - 4);
      r = 8'(base + $urandom_range(8) - 4);
    end
  endtask

  task automatic run_frame(int npix);
    logic [7:0] pb[$], pg[$], pr[$];
    logic [7:0] b, g, r;
    int mode;
    mode = $urandom_range(3);
    for (int i = 0; i < npix; i++) begin
      random_pixel(mode, b, g, r);
      pb.insert(pb.size(), b); pg.insert(pg.size(), g); pr.insert(pr.size(), r);
      send_pixel(1'b0, b, g, r, i == npix - 1);
    end
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(9) == 0)
        send_pixel(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      else send_pixel(1'b1, pb[i], pg[i], pr[i], $urandom_range(7) == 0);
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(negedge clk);
    rst_n = 1;
    send_pixel(1'b1, 8'd200, 8'd200, 8'd200, 1'b0);
    send_pixel(1'b1, 8'd0, 8'd0, 8'd0, 1'b1);
    drain();
    send_pixel(1'b0, 8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(1'b1, 8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(1'b1, 8'd250, 8'd255, 8'd252, 1'b0);
    drain();
    send_pixel(1'b0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(1'b0, 8'd255, 8'd0, 8'd255, 1'b0);
    send_pixel(1'b0, 8'd0, 8'd255, 8'd0, 1'b1);
    send_pixel(1'b1, 8'd128, 8'd128, 8'd128, 1'b0);
    send_pixel(1'b1, 8'd255, 8'd0, 8'd128, 1'b0);
    drain();
    send_pixel(1'b0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(1'b0, 8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(1'b1, 8'd1, 8'd1, 8'd1, 1'b0);
    send_pixel(1'b1, 8'd170, 8'd85, 8'd85, 1'b0);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 63 : 35) : 0;
      recv_stall = (ph == 2) ? 63 : ((ph == 3) ? 35 : 0);
      if (ph == 0) begin
        hold_off = 300;
        for (int i = 0; i < 40; i++)
          send_pixel(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        drain();
      end
      for (int f = 0; f < 20; f++) run_frame($urandom_range(1, 18));
      drain();
    end
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire
